// ===== hdl/aes_cmac_tag_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef AES_CMAC_TAG_CORE_ASSERT_SVH
`define AES_CMAC_TAG_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ACMAC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acmac assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ACMAC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acmac assertion failed");

`endif

// ===== hdl/acmac_pkg.sv =====
package acmac_pkg;

   typedef struct packed {
      logic [63:0] data_hi;
      logic [63:0] data_lo;
      logic [4:0]  byte_count;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_hi;
      logic [63:0] tag_lo;
      logic        error;
   } rsp_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;

   localparam logic [1:0] KS_128 = 2'd0;
   localparam logic [1:0] KS_192 = 2'd1;
   localparam logic [1:0] KS_256 = 2'd2;

   localparam logic [7:0] CMAC_RB  = 8'h87;
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       exp_init;
      logic       exp_step;
      logic [5:0] word;
      logic       aes_load;
      logic       zero_src;
      logic       aes_round;
      logic [3:0] round;
      logic       final_round;
      logic       set_sub;
      logic       set_chain;
      logic       out_tag;
      logic       out_err;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] key_size;
      logic       blk_err;
      logic       blk_last;
   } sts_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] v);
      gf_double = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CMAC_RB : 8'h00)};
   endfunction

   function automatic logic [3:0] rounds_of(input logic [1:0] ks);
      case (ks)
         KS_128:  rounds_of = 4'd10;
         KS_192:  rounds_of = 4'd12;
         default: rounds_of = 4'd14;
      endcase
   endfunction

   function automatic logic [3:0] nk_of(input logic [1:0] ks);
      case (ks)
         KS_128:  nk_of = 4'd4;
         KS_192:  nk_of = 4'd6;
         default: nk_of = 4'd8;
      endcase
   endfunction

   // Index of the last expanded key word: 4 * (rounds + 1) - 1.
   function automatic logic [5:0] last_word_of(input logic [1:0] ks);
      case (ks)
         KS_128:  last_word_of = 6'd43;
         KS_192:  last_word_of = 6'd51;
         default: last_word_of = 6'd59;
      endcase
   endfunction

endpackage

// ===== hdl/acmac_ctrl.sv =====
module acmac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_valid,
   input  logic [2:0]        csr_index,
   input  acmac_pkg::sts_type sts,
   output acmac_pkg::cmd_type cmd
);
   import acmac_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] word_ff, word_in;
   logic [3:0] round_ff, round_in;
   logic       kgen_ff, kgen_in;
   logic       keys_ready_ff, keys_ready_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       csr_hit;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign csr_hit   = csr_valid && (csr_index <= CSR_KEY_WORD_3);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      round_in      = round_ff;
      kgen_in       = kgen_ff;
      keys_ready_in = keys_ready_ff;
      cmd           = '0;
      cmd.word      = word_ff;
      cmd.round     = round_ff;
      cmd.zero_src  = kgen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture  = 1'b1;
               cmd.exp_init = 1'b1;
               word_in      = '0;
               kgen_in      = !keys_ready_ff;
               state_in     = keys_ready_ff ? ST_LOAD : ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            cmd.exp_step = 1'b1;
            word_in      = word_ff + 6'd1;
            if (word_ff == last_word_of(sts.key_size)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!kgen_ff && sts.blk_err) begin
               state_in = ST_FINISH;
            end else begin
               cmd.aes_load = 1'b1;
               round_in     = 4'd1;
               state_in     = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.aes_round   = 1'b1;
            cmd.final_round = (round_ff == rounds_of(sts.key_size));
            round_in        = round_ff + 4'd1;
            if (cmd.final_round) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (kgen_ff) begin
               cmd.set_sub   = 1'b1;
               keys_ready_in = 1'b1;
               kgen_in       = 1'b0;
               state_in      = ST_LOAD;
            end else if (out_free) begin
               if (sts.blk_err) begin
                  cmd.out_err = 1'b1;
               end else if (sts.blk_last) begin
                  cmd.out_tag = 1'b1;
               end else begin
                  cmd.set_chain = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_hit) begin
         keys_ready_in = 1'b0;
      end
      if (cmd.out_err || cmd.out_tag) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         word_ff       <= '0;
         round_ff      <= '0;
         kgen_ff       <= 1'b0;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_ff       <= word_in;
         round_ff      <= round_in;
         kgen_ff       <= kgen_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/acmac_dp.sv =====
module acmac_dp (
   input  logic              clock,
   input  logic              reset,
   input  acmac_pkg::req_type req_data,
   output acmac_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata,
   input  acmac_pkg::cmd_type cmd,
   output acmac_pkg::sts_type sts
);
   import acmac_pkg::*;

   logic [1:0]   ks_ff, ks_in;
   logic [255:0] key_ff, key_in;
   req_type      req_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] sub1_ff, sub1_in;
   logic [127:0] sub2_ff, sub2_in;
   logic [127:0] aes_ff;
   logic [127:0] rk_ff [15];
   logic [31:0]  win_ff [8];
   logic [2:0]   mod_ff;
   logic [7:0]   rcon_ff;
   rsp_type      rsp_ff;

   logic [3:0]   nk;
   logic         blk_full;
   logic [3:0]   cnt;
   logic [127:0] blk;
   logic [31:0]  prev;
   logic [31:0]  far;
   logic [31:0]  tmp;
   logic [31:0]  new_word;
   logic [127:0] sub_bytes;
   logic [127:0] mixed;
   logic [127:0] round_out;
   logic [7:0]   col [4];
   logic [7:0]   all;
   logic [127:0] l_dbl;

   assign nk       = nk_of(ks_ff);
   assign blk_full = req_ff.byte_count[4];
   assign cnt      = req_ff.byte_count[3:0];
   assign sts.key_size = ks_ff;
   assign sts.blk_last = req_ff.last;
   assign sts.blk_err  = !req_ff.last && !blk_full;
   assign rsp_data = rsp_ff;

   // Configuration registers.
   always_comb begin
      ks_in  = ks_ff;
      key_in = key_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_SIZE:   ks_in = (csr_wdata[1:0] == 2'd3) ? KS_256 : csr_wdata[1:0];
            CSR_KEY_WORD_0: key_in[255:192] = csr_wdata;
            CSR_KEY_WORD_1: key_in[191:128] = csr_wdata;
            CSR_KEY_WORD_2: key_in[127:64]  = csr_wdata;
            CSR_KEY_WORD_3: key_in[63:0]    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Last block formatting: 10* padding and subkey mix.
   always_comb begin
      for (int b = 0; b < 16; b++) begin
         if (blk_full || (4'(b) < cnt)) begin
            blk[127-8*b -: 8] = (b < 8) ? req_ff.data_hi[63-8*b -: 8]
                                        : req_ff.data_lo[63-8*(b-8) -: 8];
         end else if (4'(b) == cnt) begin
            blk[127-8*b -: 8] = PAD_MARK;
         end else begin
            blk[127-8*b -: 8] = 8'h00;
         end
      end
      if (req_ff.last) begin
         blk = blk ^ (blk_full ? sub1_ff : sub2_ff);
      end
   end

   // One key schedule word per cycle.
   always_comb begin
      prev = win_ff[0];
      far  = win_ff[nk[2:0] - 3'd1];
      tmp  = prev;
      if (mod_ff == 3'd0) begin
         tmp = {SBOX[prev[23:16]] ^ rcon_ff, SBOX[prev[15:8]],
                SBOX[prev[7:0]], SBOX[prev[31:24]]};
      end else if (nk == 4'd8 && mod_ff == 3'd4) begin
         tmp = {SBOX[prev[31:24]], SBOX[prev[23:16]],
                SBOX[prev[15:8]], SBOX[prev[7:0]]};
      end
      if ({2'b00, cmd.word} < {4'd0, nk}) begin
         new_word = key_ff[255 - 32*cmd.word[2:0] -: 32];
      end else begin
         new_word = far ^ tmp;
      end
   end

   // One cipher round.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sub_bytes[127-8*(i+4*c) -: 8] =
               SBOX[aes_ff[127-8*(i+4*((c+i)%4)) -: 8]];
         end
      end
      mixed = sub_bytes;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            col[i] = sub_bytes[127-8*(i+4*c) -: 8];
         end
         all = col[0] ^ col[1] ^ col[2] ^ col[3];
         for (int i = 0; i < 4; i++) begin
            mixed[127-8*(i+4*c) -: 8] = col[i] ^ all ^ xtime(col[i] ^ col[(i+1)%4]);
         end
      end
      round_out = (cmd.final_round ? sub_bytes : mixed) ^ rk_ff[cmd.round];
   end

   always_comb begin
      l_dbl    = gf_double(aes_ff);
      sub1_in  = cmd.set_sub ? l_dbl : sub1_ff;
      sub2_in  = cmd.set_sub ? gf_double(l_dbl) : sub2_ff;
      chain_in = chain_ff;
      if (cmd.set_chain) begin
         chain_in = aes_ff;
      end else if (cmd.out_tag || cmd.out_err) begin
         chain_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff    <= KS_128;
         key_ff   <= '0;
         chain_ff <= '0;
         sub1_ff  <= '0;
         sub2_ff  <= '0;
      end else begin
         ks_ff    <= ks_in;
         key_ff   <= key_in;
         chain_ff <= chain_in;
         sub1_ff  <= sub1_in;
         sub2_ff  <= sub2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.exp_init) begin
         mod_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (cmd.exp_step) begin
         mod_ff <= ({1'b0, mod_ff} == nk - 4'd1) ? 3'd0 : mod_ff + 3'd1;
         if (mod_ff == 3'd0 && {2'b00, cmd.word} >= {4'd0, nk}) begin
            rcon_ff <= xtime(rcon_ff);
         end
         win_ff[0] <= new_word;
         for (int j = 1; j < 8; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
         rk_ff[cmd.word[5:2]][127 - 32*cmd.word[1:0] -: 32] <= new_word;
      end
      if (cmd.aes_load) begin
         aes_ff <= (cmd.zero_src ? 128'd0 : (chain_ff ^ blk)) ^ rk_ff[0];
      end else if (cmd.aes_round) begin
         aes_ff <= round_out;
      end
      if (cmd.out_tag) begin
         rsp_ff <= '{tag_hi: aes_ff[127:64], tag_lo: aes_ff[63:0], error: 1'b0};
      end else if (cmd.out_err) begin
         rsp_ff <= '{tag_hi: 64'd0, tag_lo: 64'd0, error: 1'b1};
      end
   end

endmodule

// ===== hdl/aes_cmac_tag_core.sv =====
// A request is captured while idle, then runs the initial key addition, the AES
// rounds and a finish step that registers its tag; after a key write the first
// request first runs the key schedule and derives the subkeys by encrypting zero.
// The request side stalls until the finish step is through: one shared AES round.
// Reset is synchronous and active high; keys, chain and subkeys clear to zero.
module aes_cmac_tag_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  acmac_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output acmac_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import acmac_pkg::*;

   // The controller sequences key expansion, subkey derivation and the
   // rounds of each block; the datapath holds every wide register.
   cmd_type cmd;
   sts_type sts;

   // Register writes are to be made only while the block is idle; the block itself
   // does not enforce this, and the port always accepts them. Any write to a listed
   // register forces the next request to rebuild the round keys and subkeys first.
   assign csr_ready = 1'b1;

   // The controller leaves its idle state on every accepted request, so the
   // request side stalls for the whole block; a finished tag waits in the
   // output register while the next request is already being worked on.
   acmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath runs the key schedule one word per cycle, one AES round
   // per cycle, and formats the last block with padding and a subkey.
   acmac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== hdl/acmac_chk.sv =====
`include "aes_cmac_tag_core_assert.svh"

module acmac_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input acmac_pkg::rsp_type rsp_data,
   input logic               csr_valid,
   input logic               csr_ready
);
   import acmac_pkg::*;

   `ACMAC_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && rsp_stall, rsp_valid)
   `ACMAC_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.error,
                     rsp_data.tag_hi == 64'd0 && rsp_data.tag_lo == 64'd0)
   `ACMAC_ASSERT_NEXT(a_busy, !reset && req_valid && !req_stall, req_stall)
   `ACMAC_ASSERT_NOW(a_csr_ready, csr_valid, csr_ready)

endmodule

bind aes_cmac_tag_core acmac_chk u_chk (.*);

// ===== verif/tb_top.sv =====
module tb_top;
   import acmac_pkg::*;

   // Clock, reset and the block's ports.
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   aes_cmac_tag_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 300;

   // Shadow state of the tag engine, kept in step with accepted requests.
   logic [1:0]   key_len;
   logic [63:0]  key_reg [4];
   logic [127:0] chain_acc;
   logic [127:0] sub_k1;
   logic [127:0] sub_k2;
   logic [127:0] sched [15];
   bit           sched_valid;

   req_type pending_reqs [$];
   rsp_type tag_queue [$];
   int      mismatches;
   int      idle_cycles;
   bit      timed_out;
   bit      req_fire;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Byte i of a 128-bit block, with byte 0 most significant.
   function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
      byte_at = v[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] mul2(input logic [7:0] b);
      mul2 = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic int round_total();
      round_total = (key_len == KS_128) ? 10 : (key_len == KS_192) ? 12 : 14;
   endfunction

   // Key schedule into 15 round keys.
   task automatic build_schedule();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rc;
      int nk;
      int total;
      nk = (key_len == KS_128) ? 4 : (key_len == KS_192) ? 6 : 8;
      total = 4 * (round_total() + 1);
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         w[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      for (int i = nk; i < total; i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
            rc = mul2(rc);
         end else if (nk == 8 && i % 8 == 4) begin
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int r = 0; r < 15; r++)
         sched[r] = (4 * r < total) ? {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]} : '0;
   endtask

   function automatic logic [127:0] encrypt(input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] all;
      logic [7:0] c0;
      logic [127:0] v;
      int nr;
      nr = round_total();
      v = blk ^ sched[0];
      for (int r = 1; r <= nr; r++) begin
         for (int i = 0; i < 16; i++) s[i] = byte_at(v, i);
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i + 4 * c] = SBOX[s[i + 4 * ((c + i) % 4)]];
         if (r != nr) begin
            for (int c = 0; c < 4; c++) begin
               all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
               c0 = t[4*c];
               t[4*c]   ^= all ^ mul2(t[4*c] ^ t[4*c+1]);
               t[4*c+1] ^= all ^ mul2(t[4*c+1] ^ t[4*c+2]);
               t[4*c+2] ^= all ^ mul2(t[4*c+2] ^ t[4*c+3]);
               t[4*c+3] ^= all ^ mul2(t[4*c+3] ^ c0);
            end
         end
         for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = t[i];
         v = v ^ sched[r];
      end
      encrypt = v;
   endfunction

   function automatic logic [127:0] times_x(input logic [127:0] v);
      times_x = {v[126:0], 1'b0} ^ {120'd0, v[127] ? CMAC_RB : 8'h00};
   endfunction

   // Advances the shadow engine by one request and queues any tag it yields.
   task automatic predict_tag(input req_type r);
      int cnt;
      logic [127:0] blk;
      rsp_type res;
      cnt = (r.byte_count > 16) ? 16 : r.byte_count;
      if (!sched_valid) begin
         build_schedule();
         sub_k1 = times_x(encrypt('0));
         sub_k2 = times_x(sub_k1);
         sched_valid = 1'b1;
      end
      if (!r.last && cnt != 16) begin
         chain_acc = '0;
         res = '{tag_hi: 64'd0, tag_lo: 64'd0, error: 1'b1};
         tag_queue.push_back(res);
      end else begin
         blk = {r.data_hi, r.data_lo};
         if (!r.last) begin
            chain_acc = encrypt(chain_acc ^ blk);
         end else begin
            if (cnt == 16) begin
               blk = blk ^ sub_k1;
            end else begin
               blk[127 - 8 * cnt -: 8] = PAD_MARK;
               for (int i = cnt + 1; i < 16; i++) blk[127 - 8 * i -: 8] = 8'h00;
               blk = blk ^ sub_k2;
            end
            chain_acc = encrypt(chain_acc ^ blk);
            res = '{tag_hi: chain_acc[127:64], tag_lo: chain_acc[63:0], error: 1'b0};
            tag_queue.push_back(res);
            chain_acc = '0;
         end
      end
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      gap_len = (p < 40) ? 0 : (p < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   // Acceptance of a request is sampled at the rising edge.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
   end

   // Request driver: changes inputs on the falling edge, after taking note
   // of the acceptance that happened at the preceding rising edge.
   int req_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_fire) begin
            predict_tag(req_data);
            void'(pending_reqs.pop_front());
            req_gap = gap_len();
         end
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stall, comparison at the rising edge.
   int rsp_gap;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_gap = gap_len();
         rsp_stall <= (rsp_gap > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tag_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected tag result: %h %h err=%b",
                        rsp_data.tag_hi, rsp_data.tag_lo, rsp_data.error);
         end else begin
            if (rsp_data.tag_hi !== tag_queue[0].tag_hi
                || rsp_data.tag_lo !== tag_queue[0].tag_lo
                || rsp_data.error !== tag_queue[0].error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tag mismatch: expected %h %h err=%b, got %h %h err=%b",
                           tag_queue[0].tag_hi, tag_queue[0].tag_lo, tag_queue[0].error,
                           rsp_data.tag_hi, rsp_data.tag_lo, rsp_data.error);
            end
            void'(tag_queue.pop_front());
         end
      end
   end

   // Watchdog: counts cycles in which no request, result or register write
   // is accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Register write through the configuration port; the shadow copy is
   // updated at the accepting edge.
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_SIZE)
         key_len = (val[1:0] == 2'd3) ? KS_256 : val[1:0];
      else
         key_reg[idx - 1] = val;
      sched_valid = 1'b0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every request is taken and every tag has come back, then
   // lets the block settle in case a chaining block is still in flight.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || tag_queue.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      write_reg(CSR_KEY_SIZE, {62'd0, ks});
      write_reg(CSR_KEY_WORD_0, k0);
      write_reg(CSR_KEY_WORD_1, k1);
      write_reg(CSR_KEY_WORD_2, k2);
      write_reg(CSR_KEY_WORD_3, k3);
   endtask

   function automatic req_type make_req(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic [4:0] cnt, input logic lst);
      make_req = '{data_hi: hi, data_lo: lo, byte_count: cnt, last: lst};
   endfunction

   function automatic logic [63:0] rand64();
      rand64 = {$urandom(), $urandom()};
   endfunction

   // Queues one random message: mostly well-formed, sometimes broken by a
   // short middle block, with unusual byte counts on the last block.
   task automatic queue_message();
      int nblk;
      int p;
      logic [4:0] cnt;
      nblk = $urandom_range(0, 3);
      for (int i = 0; i < nblk; i++) begin
         p = $urandom_range(0, 99);
         cnt = (p < 8) ? 5'($urandom_range(0, 31)) : (p < 12) ? 5'($urandom_range(17, 31)) : 5'd16;
         pending_reqs.push_back(make_req(rand64(), rand64(), cnt, 1'b0));
      end
      p = $urandom_range(0, 99);
      cnt = (p < 35) ? 5'd16 : (p < 45) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 15));
      pending_reqs.push_back(make_req(rand64(), rand64(), cnt, 1'b1));
   endtask

   initial begin
      logic [1:0] ks;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEY_SIZE;
      csr_wdata   = '0;
      mismatches  = 0;
      idle_cycles = 0;
      timed_out   = 1'b0;
      key_len     = KS_128;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      chain_acc   = '0;
      sub_k1      = '0;
      sub_k2      = '0;
      sched_valid = 1'b0;
      for (int i = 0; i < 15; i++) sched[i] = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the all-zero reset key: empty message, full and
      // partial last blocks, oversized counts, short middle blocks.
      pending_reqs.push_back(make_req('0, '0, 5'd0, 1'b1));
      pending_reqs.push_back(make_req('1, '1, 5'd16, 1'b1));
      pending_reqs.push_back(make_req('1, '1, 5'd16, 1'b0));
      pending_reqs.push_back(make_req('1, '1, 5'd31, 1'b1));
      pending_reqs.push_back(make_req('1, 64'h0123456789abcdef, 5'd7, 1'b1));
      pending_reqs.push_back(make_req('0, '1, 5'd15, 1'b1));
      pending_reqs.push_back(make_req('1, '0, 5'd16, 1'b0));
      pending_reqs.push_back(make_req('1, '0, 5'd9, 1'b0));
      pending_reqs.push_back(make_req('1, '1, 5'd0, 1'b0));
      pending_reqs.push_back(make_req('1, '1, 5'd20, 1'b0));
      pending_reqs.push_back(make_req('0, '0, 5'd1, 1'b1));
      drain();

      // Extremes of the key: all ones for 256 and 192 bit keys, and key size three.
      load_key(KS_256, '1, '1, '1, '1);
      pending_reqs.push_back(make_req('0, '0, 5'd0, 1'b1));
      pending_reqs.push_back(make_req(rand64(), rand64(), 5'd16, 1'b0));
      drain();
      // A key word written mid-message keeps the chain but re-derives keys.
      write_reg(CSR_KEY_WORD_1, 64'h0);
      pending_reqs.push_back(make_req('1, '1, 5'd16, 1'b1));
      drain();
      load_key(2'd3, rand64(), rand64(), rand64(), rand64());
      pending_reqs.push_back(make_req('1, '0, 5'd16, 1'b1));
      drain();
      load_key(KS_192, '1, '1, '1, '0);
      pending_reqs.push_back(make_req('0, '1, 5'd3, 1'b1));
      drain();

      // Random phases, each under a fresh key of a random size.
      for (int ph = 0; ph < 12; ph++) begin
         ks = 2'($urandom_range(0, 3));
         load_key(ks, rand64(), rand64(), rand64(), rand64());
         while (pending_reqs.size() < 76) queue_message();
         drain();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
